// File: src/lbrs_pkg.sv
package lbrs_pkg;

  // Word width of the seeds, bounds and results.
  localparam int unsigned WordW = 32;
  // Width of the plain-draw modulus.
  localparam int unsigned ModW = 31;
  // Width of the divider step counter.
  localparam int unsigned StepW = $clog2(WordW);

  // Generator constants.
  localparam logic [WordW-1:0] LcgMult   = 32'h0808_8405;
  localparam logic [WordW-1:0] MainReset = 32'd1000;
  localparam logic [WordW-1:0] MenuReset = 32'd2000;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_RANGE  = 2'd0,
    FUNC_MAIN   = 2'd1,
    FUNC_MENU   = 2'd2,
    FUNC_RESEED = 2'd3
  } lbrs_func_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } lbrs_state_e;

  // Input beat.
  typedef struct packed {
    lbrs_func_e              func;
    logic signed [WordW-1:0] bound_a;
    logic signed [WordW-1:0] bound_b;
    logic [ModW-1:0]         modulus;
    logic [WordW-1:0]        new_seed;
  } lbrs_in_t;

  // Output beat.
  typedef struct packed {
    logic signed [WordW-1:0] value;
    logic [WordW-1:0]        seed_now;
  } lbrs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic fin;
  } lbrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
  } lbrs_status_t;

endpackage

// File: src/lbrs_ctrl.sv
module lbrs_ctrl
  import lbrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  lbrs_status_t status_i,
  output lbrs_cmd_t    cmd_o
);

  lbrs_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;

  // State, step counter and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    // A waiting result beat leaves once it is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status_i.skip) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.mul = 1'b1;
          step_d    = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == StepW'(WordW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // The output register must be empty or emptying this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/lbrs_dp.sv
module lbrs_dp
  import lbrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lbrs_in_t     in_data_i,
  input  lbrs_cmd_t    cmd_i,
  output lbrs_status_t status_o,
  output lbrs_out_t    out_data_o
);

  logic [WordW-1:0] main_seed_q, main_seed_d;
  logic [WordW-1:0] menu_seed_q, menu_seed_d;
  lbrs_func_e       func_q;
  logic [WordW-1:0] lo_q, span_q, reseed_q;
  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] dvd_q, dvd_d;
  lbrs_out_t        out_q;

  logic             swap;
  logic [WordW-1:0] lo_sel, hi_sel, lo_in, span_in;
  logic [WordW-1:0] seed_cur, seed_next;
  logic [WordW:0]   trial, trial_sub;
  logic [WordW-1:0] sum;

  // Order the bounds and form the span of the beat being taken.
  always_comb begin
    swap   = in_data_i.bound_a > in_data_i.bound_b;
    lo_sel = swap ? in_data_i.bound_b : in_data_i.bound_a;
    hi_sel = swap ? in_data_i.bound_a : in_data_i.bound_b;
    if (in_data_i.func == FUNC_RANGE) begin
      lo_in   = lo_sel;
      span_in = hi_sel - lo_sel + 1'b1;
    end else begin
      lo_in   = '0;
      span_in = {1'b0, in_data_i.modulus};
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= in_data_i.func;
      lo_q     <= lo_in;
      span_q   <= span_in;
      reseed_q <= in_data_i.new_seed;
    end
  end

  // A zero span or a reseed needs no draw.
  assign status_o.skip = (span_q == '0) || (func_q == FUNC_RESEED);

  // Generator step on the selected stream.
  assign seed_cur  = (func_q == FUNC_MENU) ? menu_seed_q : main_seed_q;
  assign seed_next = seed_cur * LcgMult + 1'b1;

  always_comb begin
    main_seed_d = main_seed_q;
    menu_seed_d = menu_seed_q;
    if (cmd_i.mul) begin
      if (func_q == FUNC_MENU) begin
        menu_seed_d = seed_next;
      end else begin
        main_seed_d = seed_next;
      end
    end
    if (cmd_i.fin && func_q == FUNC_RESEED) begin
      main_seed_d = reseed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_seed_q <= MainReset;
      menu_seed_q <= MenuReset;
    end else begin
      main_seed_q <= main_seed_d;
      menu_seed_q <= menu_seed_d;
    end
  end

  // Restoring divider, one remainder bit per step.
  always_comb begin
    trial     = {rem_q, dvd_q[WordW-1]};
    trial_sub = trial - {1'b0, span_q};
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    if (cmd_i.mul) begin
      rem_d = '0;
      dvd_d = seed_next;
    end else if (cmd_i.div_step) begin
      rem_d = trial_sub[WordW] ? trial[WordW-1:0] : trial_sub[WordW-1:0];
      dvd_d = {dvd_q[WordW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  // Result beat register.
  assign sum = status_o.skip ? lo_q : rem_q + lo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.value    <= sum;
      out_q.seed_now <= (func_q == FUNC_RESEED) ? reseed_q : main_seed_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: src/lcg_bounded_random_source.sv
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    in_data_i  (lbrs_in_t)
// out      out_valid_o / out_ready_i  out_data_o (lbrs_out_t)
//
// On acceptance the operands are loaded; the generator multiply follows, then the
// restoring divider runs over all 32 dividend bits, one remainder bit a cycle, and
// a last step registers the result. The next beat can be taken in the cycle after
// the result is registered. A reseed, a zero span or a zero modulus skips the
// multiply and divider and goes straight to registering its result.
// One item is in work at a time; a new beat is taken while a finished
// result still waits in the output register, and that item then holds before its
// result is registered until the waiting beat is taken. Reset sets the main seed to
// 1000 and the menu seed to 2000.
module lcg_bounded_random_source
  import lbrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lbrs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lbrs_out_t out_data_o
);

  lbrs_cmd_t    cmd;
  lbrs_status_t status;

  // Sequencer.
  lbrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Seeds, multiplier, divider and result register.
  lbrs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
